>>> design/smi_pkg.sv
`default_nettype none

package smi_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;
  localparam int MODE_W        = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_NEXT,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_MERGE_RD,
    ST_MERGE_CMP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> design/sorted_multiset_intersection.sv
`default_nettype none
// Channel   Direction  Handshake                    Payload
// command   in         start, transfer when !busy   mode, value
// result    out        strobe, one cycle, no stall  common_value, has_value, last, overflow
//
// A load of list A or B is a single transfer; busy stays low, so loads
// stream at one per cycle. A run sorts list A then list B in place by insertion
// sort through the one read and one write port of each list memory, then
// merges with two pointers, each merge step a read state then a compare state.
// One signed comparator is shared by sort and merge. Results come out at most
// one per merge step; the last one, with last set, is on the ports in the same
// cycle that busy first reads low. Reset is synchronous and empties both lists;
// the receiver cannot stall results.
module sorted_multiset_intersection
  import smi_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [MODE_W-1:0]         mode,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           strobe,
  output logic signed [VALUE_W-1:0]      common_value,
  output logic                           has_value,
  output logic                           last,
  output logic                           overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [VALUE_W-1:0] list_a [DEPTH];
  logic [VALUE_W-1:0] list_b [DEPTH];
  logic [VALUE_W-1:0] rdata_a, rdata_b, rdata_sel;

  logic [CW-1:0] count_a, count_a_next, count_b, count_b_next;
  logic [CW-1:0] idx_i, idx_i_next, idx_j, idx_j_next, idx_k, idx_k_next;
  logic [CW-1:0] i_dec, k_dec, k_dec2, sort_n;
  logic          sel, sel_next;
  logic          dropped, dropped_next;
  logic          hold_valid, hold_valid_next;
  logic [VALUE_W-1:0] key, key_next, hold, hold_next;

  logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               we_a, we_b;

  logic [VALUE_W-1:0] cmp_x, cmp_y;
  logic               cmp_lt, cmp_eq;

  logic                      strobe_next, has_value_next, last_next, overflow_next;
  logic signed [VALUE_W-1:0] common_value_next;

  logic accept;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign rdata_sel = sel ? rdata_b : rdata_a;
  assign sort_n    = sel ? count_b : count_a;
  assign i_dec     = idx_i - CW'(1);
  assign k_dec     = idx_k - CW'(1);
  assign k_dec2    = idx_k - CW'(2);

  // shared comparator
  assign cmp_x  = (state == ST_MERGE_CMP) ? rdata_a : key;
  assign cmp_y  = (state == ST_MERGE_CMP) ? rdata_b : rdata_sel;
  assign cmp_lt = $signed(cmp_x) < $signed(cmp_y);
  assign cmp_eq = (cmp_x == cmp_y);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_RUN) state_next = ST_SORT_NEXT;
      end
      ST_SORT_NEXT: begin
        if (idx_i < sort_n) state_next = ST_SORT_KEY;
        else if (sel) state_next = ST_MERGE_RD;
      end
      ST_SORT_KEY: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (!cmp_lt) state_next = ST_SORT_NEXT;
        else if (idx_k <= CW'(1)) state_next = ST_SORT_PUT;
      end
      ST_SORT_PUT: state_next = ST_SORT_NEXT;
      ST_MERGE_RD: begin
        if (idx_i < count_a && idx_j < count_b) state_next = ST_MERGE_CMP;
        else state_next = ST_FINISH;
      end
      ST_MERGE_CMP: state_next = ST_MERGE_RD;
      ST_FINISH:    state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_a_next      = count_a;
    count_b_next      = count_b;
    idx_i_next        = idx_i;
    idx_j_next        = idx_j;
    idx_k_next        = idx_k;
    sel_next          = sel;
    dropped_next      = dropped;
    hold_valid_next   = hold_valid;
    hold_next         = hold;
    key_next          = key;
    rd_addr_a         = idx_i[AW-1:0];
    rd_addr_b         = idx_i[AW-1:0];
    wr_addr           = idx_k[AW-1:0];
    wr_data           = key;
    we_a              = 1'b0;
    we_b              = 1'b0;
    strobe_next       = 1'b0;
    common_value_next = $signed(hold);
    has_value_next    = 1'b1;
    last_next         = 1'b0;
    overflow_next     = dropped;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_LOAD_A: begin
              wr_data = value;
              wr_addr = count_a[AW-1:0];
              if (count_a < CW'(DEPTH)) begin
                we_a         = 1'b1;
                count_a_next = count_a + CW'(1);
              end else begin
                dropped_next = 1'b1;
              end
            end
            MODE_LOAD_B: begin
              wr_data = value;
              wr_addr = count_b[AW-1:0];
              if (count_b < CW'(DEPTH)) begin
                we_b         = 1'b1;
                count_b_next = count_b + CW'(1);
              end else begin
                dropped_next = 1'b1;
              end
            end
            MODE_RUN: begin
              sel_next   = 1'b0;
              idx_i_next = CW'(1);
            end
            default: ;
          endcase
        end
      end
      ST_SORT_NEXT: begin
        if (idx_i >= sort_n) begin
          if (!sel) begin
            sel_next   = 1'b1;
            idx_i_next = CW'(1);
          end else begin
            idx_i_next      = '0;
            idx_j_next      = '0;
            hold_valid_next = 1'b0;
          end
        end
      end
      ST_SORT_KEY: begin
        key_next   = rdata_sel;
        idx_k_next = idx_i;
        rd_addr_a  = i_dec[AW-1:0];
        rd_addr_b  = i_dec[AW-1:0];
      end
      ST_SORT_CMP: begin
        if (cmp_lt) begin
          wr_data    = rdata_sel;
          idx_k_next = k_dec;
          rd_addr_a  = k_dec2[AW-1:0];
          rd_addr_b  = k_dec2[AW-1:0];
        end else begin
          idx_i_next = idx_i + CW'(1);
        end
        we_a = !sel;
        we_b = sel;
      end
      ST_SORT_PUT: begin
        we_a       = !sel;
        we_b       = sel;
        idx_i_next = idx_i + CW'(1);
      end
      ST_MERGE_RD: begin
        rd_addr_a = idx_i[AW-1:0];
        rd_addr_b = idx_j[AW-1:0];
      end
      ST_MERGE_CMP: begin
        if (cmp_eq) begin
          strobe_next     = hold_valid;
          hold_next       = rdata_a;
          hold_valid_next = 1'b1;
          idx_i_next      = idx_i + CW'(1);
          idx_j_next      = idx_j + CW'(1);
        end else if (cmp_lt) begin
          idx_i_next = idx_i + CW'(1);
        end else begin
          idx_j_next = idx_j + CW'(1);
        end
      end
      ST_FINISH: begin
        strobe_next       = 1'b1;
        last_next         = 1'b1;
        has_value_next    = hold_valid;
        common_value_next = hold_valid ? $signed(hold) : '0;
        count_a_next      = '0;
        count_b_next      = '0;
        dropped_next      = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) list_a[wr_addr] <= wr_data;
    if (we_b) list_b[wr_addr] <= wr_data;
    rdata_a <= list_a[rd_addr_a];
    rdata_b <= list_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count_a    <= '0;
      count_b    <= '0;
      dropped    <= 1'b0;
      hold_valid <= 1'b0;
      sel        <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      count_a    <= count_a_next;
      count_b    <= count_b_next;
      dropped    <= dropped_next;
      hold_valid <= hold_valid_next;
      sel        <= sel_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_i        <= idx_i_next;
    idx_j        <= idx_j_next;
    idx_k        <= idx_k_next;
    key          <= key_next;
    hold         <= hold_next;
    common_value <= common_value_next;
    has_value    <= has_value_next;
    last         <= last_next;
    overflow     <= overflow_next;
  end

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result outside a run");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result while still busy");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !has_value |-> last)
    else $error("empty result not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_a <= CW'(DEPTH) && count_b <= CW'(DEPTH))
    else $error("list count beyond depth");

  a_merge_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE_CMP |-> $past(state) == ST_MERGE_RD)
    else $error("merge compare without read");

endmodule

`default_nettype wire
